### hw/rtl/color_key_run_extractor_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the color key run extractor
// Shared concurrent assertion forms, clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef COLOR_KEY_RUN_EXTRACTOR_DEFINES_SVH
`define COLOR_KEY_RUN_EXTRACTOR_DEFINES_SVH

// Checked only while out of reset.
`define CKRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define CKRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/ckre_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ckre_pkg
// Types and constants shared by the color key run extractor modules.
// ---------------------------------------------------------------------------
package ckre_pkg;

  localparam int unsigned PosW     = 13;
  localparam int unsigned ChW      = 8;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 3;

  typedef logic [PosW-1:0] pos_t;
  typedef logic [ChW-1:0]  chan_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_RED         = 3'd0,
    CFG_KEY_GREEN       = 3'd1,
    CFG_KEY_BLUE        = 3'd2,
    CFG_TOLERANCE_RED   = 3'd3,
    CFG_TOLERANCE_GREEN = 3'd4,
    CFG_TOLERANCE_BLUE  = 3'd5,
    CFG_FRAME_WIDTH     = 3'd6,
    CFG_FRAME_HEIGHT    = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    KIND_RUN = 1'b0,
    KIND_BOX = 1'b1
  } result_kind_e;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } color_t;

  typedef struct packed {
    result_kind_e kind;
    pos_t         x_low;
    pos_t         x_high;
    pos_t         y_low;
    pos_t         y_high;
    logic         last;
  } result_t;

  // Up to two results produced by one pixel, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } scan_out_t;

endpackage

### hw/rtl/ckre_classify.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ckre_classify
// Decides whether a pixel falls inside the clamped key color window.
// ---------------------------------------------------------------------------
module ckre_classify (
  input  ckre_pkg::color_t pixel_i,
  input  ckre_pkg::color_t key_i,
  input  ckre_pkg::color_t tol_i,
  output logic             transparent_o
);

  function automatic logic in_window(input ckre_pkg::chan_t v,
                                     input ckre_pkg::chan_t key,
                                     input ckre_pkg::chan_t tol);
    logic [ckre_pkg::ChW:0]   hi_sum;
    ckre_pkg::chan_t          lo;
    ckre_pkg::chan_t          hi;
    hi_sum = {1'b0, key} + {1'b0, tol};
    lo     = (key > tol) ? key - tol : '0;
    hi     = hi_sum[ckre_pkg::ChW] ? '1 : hi_sum[ckre_pkg::ChW-1:0];
    return (v >= lo) && (v <= hi);
  endfunction

  assign transparent_o = in_window(pixel_i.red,   key_i.red,   tol_i.red)   &&
                         in_window(pixel_i.green, key_i.green, tol_i.green) &&
                         in_window(pixel_i.blue,  key_i.blue,  tol_i.blue);

endmodule

### hw/rtl/ckre_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ckre_scan
// Raster position, run tracking and bounding box; builds the results of
// one pixel.
// ---------------------------------------------------------------------------
`include "color_key_run_extractor_defines.svh"

module ckre_scan #(
  parameter logic [12:0] BOUND_MAX = 13'd4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 transparent_i,
  input  ckre_pkg::pos_t       frame_width_i,
  input  ckre_pkg::pos_t       frame_height_i,
  output ckre_pkg::scan_out_t  res_o
);

  ckre_pkg::pos_t col_q, col_d, row_q, row_d, start_q, start_d;
  logic           active_q, active_d;
  ckre_pkg::pos_t left_q, left_d, top_q, top_d, right_q, right_d, bottom_q, bottom_d;

  logic [ckre_pkg::PosW:0] col_inc, row_inc;
  ckre_pkg::pos_t          next_col, next_row;
  logic                    row_end, frame_end;
  logic                    emit;
  ckre_pkg::pos_t          run_x0, run_x1;
  ckre_pkg::pos_t          left_n, top_n, right_n, bottom_n;
  ckre_pkg::result_t       run_res, box_res;

  assign col_inc   = {1'b0, col_q} + 14'd1;
  assign row_inc   = {1'b0, row_q} + 14'd1;
  assign next_col  = col_inc[ckre_pkg::PosW-1:0];
  assign next_row  = row_inc[ckre_pkg::PosW-1:0];
  assign row_end   = col_inc >= {1'b0, frame_width_i};
  assign frame_end = row_end && (row_inc >= {1'b0, frame_height_i});

  // A transparent pixel closes an open run before itself; an opaque pixel
  // at the row end closes the run including itself.
  always_comb begin
    if (transparent_i) begin
      emit   = active_q;
      run_x0 = start_q;
      run_x1 = col_q;
    end else begin
      emit   = row_end;
      run_x0 = active_q ? start_q : col_q;
      run_x1 = next_col;
    end
  end

  assign left_n   = (emit && run_x0 < left_q)     ? run_x0   : left_q;
  assign top_n    = (emit && row_q < top_q)       ? row_q    : top_q;
  assign right_n  = (emit && run_x1 > right_q)    ? run_x1   : right_q;
  assign bottom_n = (emit && next_row > bottom_q) ? next_row : bottom_q;

  always_comb begin
    run_res.kind   = ckre_pkg::KIND_RUN;
    run_res.x_low  = run_x0;
    run_res.x_high = run_x1;
    run_res.y_low  = row_q;
    run_res.y_high = next_row;
    run_res.last   = !frame_end;

    box_res.kind   = ckre_pkg::KIND_BOX;
    box_res.x_low  = left_n;
    box_res.x_high = right_n;
    box_res.y_low  = top_n;
    box_res.y_high = bottom_n;
    box_res.last   = 1'b1;

    if (emit) begin
      res_o.first  = run_res;
      res_o.second = box_res;
      res_o.count  = frame_end ? 2'd2 : 2'd1;
    end else begin
      res_o.first  = box_res;
      res_o.second = box_res;
      res_o.count  = frame_end ? 2'd1 : 2'd0;
    end
  end

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    start_d  = start_q;
    active_d = active_q;
    left_d   = left_q;
    top_d    = top_q;
    right_d  = right_q;
    bottom_d = bottom_q;
    if (step_i) begin
      if (!transparent_i && !active_q) begin
        start_d = col_q;
      end
      active_d = !transparent_i && !row_end;
      col_d    = row_end ? '0 : next_col;
      if (frame_end) begin
        row_d    = '0;
        left_d   = BOUND_MAX;
        top_d    = BOUND_MAX;
        right_d  = '0;
        bottom_d = '0;
      end else begin
        row_d    = row_end ? next_row : row_q;
        left_d   = left_n;
        top_d    = top_n;
        right_d  = right_n;
        bottom_d = bottom_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      start_q  <= '0;
      active_q <= 1'b0;
      left_q   <= BOUND_MAX;
      top_q    <= BOUND_MAX;
      right_q  <= '0;
      bottom_q <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      start_q  <= start_d;
      active_q <= active_d;
      left_q   <= left_d;
      top_q    <= top_d;
      right_q  <= right_d;
      bottom_q <= bottom_d;
    end
  end

  `CKRE_ASSERT(a_box_comes_last, res_o.count == 2'd2 |-> res_o.first.kind == ckre_pkg::KIND_RUN && res_o.second.kind == ckre_pkg::KIND_BOX, "two results must be a run followed by the box")
  `CKRE_ASSERT(a_bounds_clear_after_frame, step_i && frame_end |=> left_q == BOUND_MAX && right_q == '0 && bottom_q == '0, "bounding box not cleared after frame end")

endmodule

### hw/rtl/ckre_out_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ckre_out_fifo
// Small result queue that takes up to two results per cycle while it has
// room and delivers one per cycle while out_stall_i is low.
// ---------------------------------------------------------------------------
`include "color_key_run_extractor_defines.svh"

module ckre_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ckre_pkg::scan_out_t push_data_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ckre_pkg::result_t   out_data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ckre_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [1:0]        push_n;
  logic              pop;

  assign push_n      = push_i ? push_data_i.count : 2'd0;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  // Room is judged without the pop of this cycle, so a full pair always fits.
  assign space_o     = count_q <= CntW'(Depth - 2);

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_n);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + CntW'(push_n) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_data_i.first;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_data_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `CKRE_ASSERT(a_push_has_room, push_n != 2'd0 |-> count_q <= CntW'(Depth - 2), "result queue pushed without room")
  `CKRE_ASSERT_ALWAYS(a_count_bounded, !rst_ni || count_q <= CntW'(Depth), "result queue count out of range")

endmodule

### hw/rtl/color_key_run_extractor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// color_key_run_extractor
// Splits a color-keyed RGB frame into opaque horizontal runs and reports the
// frame's bounding box.
// ---------------------------------------------------------------------------
// The block accepts one pixel per clock in raster order while in_stall_o is
// low and returns one run rectangle for every maximal horizontal run of
// non-key pixels in a row, followed after the last pixel of the frame by the
// bounding box of all runs (left and top at the maximum, right and bottom at
// zero for an empty frame). An accepted pixel is classified in the input
// register and scanned once the result queue has room. The output port
// delivers one result per clock from a four-entry queue while out_stall_i is
// low, so the sustained rate is one pixel per clock; a pixel that closes a
// run and the frame together yields two results. The user must write
// configuration through cfg_we_i, cfg_index_i and cfg_data_i while no item
// is in flight; the block itself does not enforce it.
// ---------------------------------------------------------------------------
`include "color_key_run_extractor_defines.svh"

module color_key_run_extractor #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_we_i,
  input  logic [ckre_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ckre_pkg::CfgDataW-1:0]     cfg_data_i,

  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ckre_pkg::chan_t                   pixel_red_i,
  input  ckre_pkg::chan_t                   pixel_green_i,
  input  ckre_pkg::chan_t                   pixel_blue_i,

  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              result_kind_o,
  output ckre_pkg::pos_t                    x_low_o,
  output ckre_pkg::pos_t                    x_high_o,
  output ckre_pkg::pos_t                    y_low_o,
  output ckre_pkg::pos_t                    y_high_o,
  output logic                              last_of_item_o
);

  localparam int unsigned BoundMaxInt = (MAX_DIMENSION > 8191) ? 8191 : MAX_DIMENSION;
  localparam logic [12:0] BoundMax    = 13'(BoundMaxInt);

  ckre_pkg::color_t    key_q, tol_q;
  ckre_pkg::pos_t      width_q, height_q;
  ckre_pkg::color_t    pixel_q;
  logic                in_valid_q;
  logic                load, fire, space, transparent;
  ckre_pkg::scan_out_t scan_res;
  ckre_pkg::result_t   out_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      tol_q    <= '0;
      width_q  <= 13'd640;
      height_q <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (ckre_pkg::cfg_reg_e'(cfg_index_i))
        ckre_pkg::CFG_KEY_RED:         key_q.red   <= cfg_data_i[ckre_pkg::ChW-1:0];
        ckre_pkg::CFG_KEY_GREEN:       key_q.green <= cfg_data_i[ckre_pkg::ChW-1:0];
        ckre_pkg::CFG_KEY_BLUE:        key_q.blue  <= cfg_data_i[ckre_pkg::ChW-1:0];
        ckre_pkg::CFG_TOLERANCE_RED:   tol_q.red   <= cfg_data_i[ckre_pkg::ChW-1:0];
        ckre_pkg::CFG_TOLERANCE_GREEN: tol_q.green <= cfg_data_i[ckre_pkg::ChW-1:0];
        ckre_pkg::CFG_TOLERANCE_BLUE:  tol_q.blue  <= cfg_data_i[ckre_pkg::ChW-1:0];
        ckre_pkg::CFG_FRAME_WIDTH:     width_q     <= cfg_data_i;
        ckre_pkg::CFG_FRAME_HEIGHT:    height_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: a held item is scanned once the result queue has room.
  assign fire       = in_valid_q && space;
  assign in_stall_o = in_valid_q && !fire;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= load || (in_valid_q && !fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pixel_q.red   <= pixel_red_i;
      pixel_q.green <= pixel_green_i;
      pixel_q.blue  <= pixel_blue_i;
    end
  end

  ckre_classify u_classify (
    .pixel_i       (pixel_q),
    .key_i         (key_q),
    .tol_i         (tol_q),
    .transparent_o (transparent)
  );

  ckre_scan #(
    .BOUND_MAX (BoundMax)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (fire),
    .transparent_i  (transparent),
    .frame_width_i  (width_q),
    .frame_height_i (height_q),
    .res_o          (scan_res)
  );

  ckre_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .push_data_i (scan_res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign result_kind_o  = out_data.kind;
  assign x_low_o        = out_data.x_low;
  assign x_high_o       = out_data.x_high;
  assign y_low_o        = out_data.y_low;
  assign y_high_o       = out_data.y_high;
  assign last_of_item_o = out_data.last;

  `CKRE_ASSERT(a_held_item_kept, in_valid_q && !fire |=> in_valid_q && $stable(pixel_q), "held item lost before it was scanned")

endmodule
